>>> rtl/cubic_bezier_trajectory_eval_macros.svh
// assertion macros shared by the bezier trajectory evaluator modules
`ifndef CUBIC_BEZIER_TRAJECTORY_EVAL_MACROS_SVH
`define CUBIC_BEZIER_TRAJECTORY_EVAL_MACROS_SVH

// same-cycle implication, checked on clk and held off during reset
`define CBZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and held off during reset
`define CBZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cbz_pkg.sv
// shared types and constants of the cubic bezier trajectory evaluator
package cbz_pkg;

  localparam int COORD_W   = 16;
  localparam int VEL_W     = 20;
  localparam int TIME_W    = 16;
  localparam int ELAPSED_W = 20;
  localparam int T_W       = 17;
  localparam int POINT_W   = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int OUT_DATA_W = 112;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [T_W-1:0]       T_ONE       = 17'h10000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [TIME_W-1:0]    DUR_RESET   = 16'h1000;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_START_POINT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_CTRL    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_CTRL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_END_POINT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DURATION      = 3'd4;

  // last step of the weight and lane sequences
  localparam logic [2:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_DIV,
    EV_SCAL,
    EV_LANE,
    EV_WRITE
  } eval_state_t;

  // one classified item in the queue between front and back
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic              done;
  } cbz_item_t;

endpackage

>>> rtl/cbz_front.sv
// front end: keeps elapsed time and classifies each beat before queuing
module cbz_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cbz_pkg::TIME_W-1:0]  in_tdata,   // time_step
  input  logic                        in_tuser,   // restart
  input  logic [cbz_pkg::TIME_W-1:0]  dur,
  input  logic                        q_full,
  output logic                        q_push,
  output cbz_pkg::cbz_item_t          q_item
);
  import cbz_pkg::*;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] base;
  logic [ELAPSED_W:0]   sum;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // saturating elapsed-time update
  always_comb begin
    base = in_tuser ? '0 : elapsed_r;
    sum  = {1'b0, base} + {{(ELAPSED_W + 1 - TIME_W){1'b0}}, in_tdata};
    elapsed_nxt = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
  end

  // classify: finished items need no division
  always_comb begin
    q_item.done    = elapsed_nxt >= {{(ELAPSED_W - TIME_W){1'b0}}, dur};
    q_item.elapsed = elapsed_nxt[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (q_push) begin
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

>>> rtl/cbz_fifo.sv
// short queue of classified items between front and back
`include "cubic_bezier_trajectory_eval_macros.svh"
module cbz_fifo #(
  parameter int DEPTH = cbz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  cbz_pkg::cbz_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output cbz_pkg::cbz_item_t rd_data,
  output logic               empty
);
  import cbz_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbz_item_t         mem [DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `CBZ_ASSERT_IMP(a_no_overflow, wr_en, !full, "queue written while full")
  `CBZ_ASSERT_IMP(a_no_underflow, rd_en, !empty, "queue read while empty")
  `CBZ_ASSERT_NXT(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

>>> rtl/cbz_div.sv
// restoring divider, one quotient bit a cycle, for t = elapsed / duration
module cbz_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cbz_pkg::TIME_W-1:0] num,
  input  logic [cbz_pkg::TIME_W-1:0] den,
  output logic                       done,
  output logic [cbz_pkg::TIME_W-1:0] quot
);
  import cbz_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] rem_r, quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [TIME_W:0]   shifted, diff;
  logic              ge;

  // one shift-and-subtract step; the partial remainder stays below den
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(TIME_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= num;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo_r <= {quo_r[TIME_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> rtl/cbz_eval.sv
// back end: bernstein weights on a shared multiplier, then x/y/z lanes
`include "cubic_bezier_trajectory_eval_macros.svh"
module cbz_eval (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  cbz_pkg::cbz_item_t             q_item,
  output logic                           q_pop,
  input  logic [cbz_pkg::POINT_W-1:0]    p0,
  input  logic [cbz_pkg::POINT_W-1:0]    p1,
  input  logic [cbz_pkg::POINT_W-1:0]    p2,
  input  logic [cbz_pkg::POINT_W-1:0]    p3,
  output logic                           div_start,
  input  logic                           div_done,
  input  logic [cbz_pkg::TIME_W-1:0]     div_quot,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero fill
  output logic [cbz_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser  // finished
);
  import cbz_pkg::*;

  eval_state_t state_r, state_nxt;
  logic [2:0]     step_r;
  logic [T_W-1:0] t_r, u;
  logic           fin_r;

  logic [32:0] uu_r, tt_r;
  logic [48:0] w0_r, w1_r, w2_r, w3_r;
  logic [33:0] d0_r, d1_r, d2_r;
  logic [49:0] w3x;

  logic signed [49:0] mul_a [3];
  logic signed [17:0] mul_b [3];
  logic signed [67:0] prod_r [3];

  logic [63:0]        pos_acc_r [3];
  logic signed [53:0] vel_acc_r [3];

  logic [15:0]        crd  [3][4];
  logic [15:0]        offs [3][4];
  logic signed [16:0] dif  [3][3];

  logic [63:0]        pos_rnd [3];
  logic signed [53:0] vel_rnd [3];
  logic [21:0]        vel_q   [3];
  logic [COORD_W-1:0] pos_out [3];
  logic [VEL_W-1:0]   vel_out [3];

  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic out_user_r;
  logic load_out;

  assign u = T_ONE - t_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EV_IDLE:  if (!q_empty) state_nxt = q_item.done ? EV_SCAL : EV_DIV;
      EV_DIV:   if (div_done) state_nxt = EV_SCAL;
      EV_SCAL:  if (step_r == STEP_LAST) state_nxt = EV_LANE;
      EV_LANE:  if (step_r == STEP_LAST) state_nxt = EV_WRITE;
      EV_WRITE: if (!out_valid_r || out_tready) state_nxt = EV_IDLE;
      default:  state_nxt = EV_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      EV_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty && !q_item.done;
      end
      EV_WRITE: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EV_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == EV_SCAL || state_r == EV_LANE) && step_r != STEP_LAST) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  // coordinates, unsigned offsets and differences per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd[k][0] = p0[16*k +: 16];
      crd[k][1] = p1[16*k +: 16];
      crd[k][2] = p2[16*k +: 16];
      crd[k][3] = p3[16*k +: 16];
      for (int i = 0; i < 4; i++) begin
        offs[k][i] = {~crd[k][i][15], crd[k][i][14:0]};
      end
      for (int i = 0; i < 3; i++) begin
        dif[k][i] = $signed({crd[k][i+1][15], crd[k][i+1]})
                  - $signed({crd[k][i][15], crd[k][i]});
      end
    end
  end

  // multiplier operand selection
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_a[k] = '0;
      mul_b[k] = '0;
      if (state_r == EV_SCAL) begin
        case (step_r)
          3'd0: begin mul_a[k] = $signed(50'(u));    mul_b[k] = $signed({1'b0, u}); end
          3'd1: begin mul_a[k] = $signed(50'(t_r));  mul_b[k] = $signed({1'b0, t_r}); end
          3'd2: begin mul_a[k] = $signed(50'(u));    mul_b[k] = $signed({1'b0, t_r}); end
          3'd3: begin mul_a[k] = $signed(50'(uu_r)); mul_b[k] = $signed({1'b0, u}); end
          3'd4: begin mul_a[k] = $signed(50'(uu_r)); mul_b[k] = $signed({1'b0, t_r}); end
          3'd5: begin mul_a[k] = $signed(50'(tt_r)); mul_b[k] = $signed({1'b0, u}); end
          3'd6: begin mul_a[k] = $signed(50'(tt_r)); mul_b[k] = $signed({1'b0, t_r}); end
          default: ;
        endcase
      end else if (state_r == EV_LANE) begin
        case (step_r)
          3'd0: begin mul_a[k] = $signed(50'(w0_r)); mul_b[k] = $signed(18'(offs[k][0])); end
          3'd1: begin mul_a[k] = $signed(50'(w1_r)); mul_b[k] = $signed(18'(offs[k][1])); end
          3'd2: begin mul_a[k] = $signed(50'(w2_r)); mul_b[k] = $signed(18'(offs[k][2])); end
          3'd3: begin mul_a[k] = $signed(50'(w3_r)); mul_b[k] = $signed(18'(offs[k][3])); end
          3'd4: begin mul_a[k] = $signed(50'(d0_r)); mul_b[k] = 18'(dif[k][0]); end
          3'd5: begin mul_a[k] = $signed(50'(d1_r)); mul_b[k] = 18'(dif[k][1]); end
          3'd6: begin mul_a[k] = $signed(50'(d2_r)); mul_b[k] = 18'(dif[k][2]); end
          default: ;
        endcase
      end
    end
  end

  // registered products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= mul_a[k] * mul_b[k];
    end
  end

  // three times a weight, still below one in Q0.48
  assign w3x = {prod_r[0][48:0], 1'b0} + {1'b0, prod_r[0][48:0]};

  // parameter t, weights and lane accumulators
  always_ff @(posedge clk) begin
    if (state_r == EV_IDLE && !q_empty) begin
      fin_r <= q_item.done;
      t_r   <= T_ONE;
    end
    if (state_r == EV_DIV && div_done) begin
      t_r <= {1'b0, div_quot};
    end
    if (state_r == EV_SCAL) begin
      case (step_r)
        3'd1: begin
          uu_r <= prod_r[0][32:0];
          d0_r <= {prod_r[0][32:0], 1'b0} + {1'b0, prod_r[0][32:0]};
        end
        3'd2: begin
          tt_r <= prod_r[0][32:0];
          d2_r <= {prod_r[0][32:0], 1'b0} + {1'b0, prod_r[0][32:0]};
        end
        3'd3: d1_r <= {1'b0, prod_r[0][30:0], 2'b00} + {2'b00, prod_r[0][30:0], 1'b0};
        3'd4: w0_r <= prod_r[0][48:0];
        3'd5: w1_r <= w3x[48:0];
        3'd6: w2_r <= w3x[48:0];
        3'd7: w3_r <= prod_r[0][48:0];
        default: ;
      endcase
    end
    if (state_r == EV_LANE) begin
      for (int k = 0; k < 3; k++) begin
        case (step_r)
          3'd1:       pos_acc_r[k] <= prod_r[k][63:0];
          3'd2, 3'd3,
          3'd4:       pos_acc_r[k] <= pos_acc_r[k] + prod_r[k][63:0];
          3'd5:       vel_acc_r[k] <= prod_r[k][53:0];
          3'd6, 3'd7: vel_acc_r[k] <= vel_acc_r[k] + prod_r[k][53:0];
          default: ;
        endcase
      end
    end
  end

  // rounding, and saturation of the velocities
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_rnd[k] = pos_acc_r[k] + 64'h0000_8000_0000_0000;
      pos_out[k] = {~pos_rnd[k][63], pos_rnd[k][62:48]};
      vel_rnd[k] = vel_acc_r[k] + 54'sh0_8000_0000;
      vel_q[k]   = vel_rnd[k][53:32];
      if (vel_q[k][21:19] == 3'b000 || vel_q[k][21:19] == 3'b111) begin
        vel_out[k] = vel_q[k][19:0];
      end else begin
        vel_out[k] = vel_q[k][21] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {4'b0000, vel_out[2], vel_out[1], vel_out[0],
                     pos_out[2], pos_out[1], pos_out[0]};
      out_user_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CBZ_ASSERT_IMP(a_load_from_write, $rose(out_valid_r), $past(state_r == EV_WRITE), "result loaded outside writeback")
  `CBZ_ASSERT_NXT(a_done_skips_div, q_pop && q_item.done, state_r == EV_SCAL && t_r == T_ONE, "finished item did not skip divider")
  `CBZ_ASSERT_IMP(a_div_done_in_div, div_done, state_r == EV_DIV, "divider finished while not awaited")

endmodule

>>> rtl/cubic_bezier_trajectory_eval.sv
// top level of the cubic bezier trajectory evaluator
// Each input beat advances a saturating elapsed-time counter (or restarts it) and yields
// one result beat with the curve position, its derivative with respect to t and a finished
// flag. An item goes from the queue to the result register through a pop, the restoring
// divider that forms t one quotient bit a cycle, the Bernstein weights on one shared
// multiplier, the x/y/z lanes and writeback; an item already at or past the duration
// skips the divider. The input side keeps taking beats into a short queue, until it is
// full, while the back end works or a result waits.
module cubic_bezier_trajectory_eval #(
  parameter int QUEUE_DEPTH = cbz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cbz_pkg::TIME_W-1:0]      in_tdata,   // time_step
  input  logic                            in_tuser,   // restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero fill
  output logic [cbz_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser,  // finished
  input  logic                            cfg_wr_en,
  input  logic [cbz_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cbz_pkg::POINT_W-1:0]     cfg_wdata
);
  import cbz_pkg::*;

  logic [POINT_W-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [TIME_W-1:0]  dur_r;

  logic      q_full, q_empty, q_push, q_pop;
  cbz_item_t q_wr_item, q_rd_item;
  logic      div_start, div_done;
  logic [TIME_W-1:0] div_quot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r  <= '0;
      p1_r  <= '0;
      p2_r  <= '0;
      p3_r  <= '0;
      dur_r <= DUR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_START_POINT: p0_r  <= cfg_wdata;
        REG_FIRST_CTRL:  p1_r  <= cfg_wdata;
        REG_SECOND_CTRL: p2_r  <= cfg_wdata;
        REG_END_POINT:   p3_r  <= cfg_wdata;
        REG_DURATION:    dur_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  cbz_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .dur       (dur_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  cbz_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  cbz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (q_rd_item.elapsed),
    .den   (dur_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  cbz_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .p0         (p0_r),
    .p1         (p1_r),
    .p2         (p2_r),
    .p3         (p3_r),
    .div_start  (div_start),
    .div_done   (div_done),
    .div_quot   (div_quot),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
